### rtl/grdda_pkg.sv
// Shared types, constants and codes for the grid ray caster.
package grdda_pkg;

  localparam int MAP_W     = 64;
  localparam int MAP_H     = 64;
  localparam int MAX_STEPS = 128;
  localparam int XW        = $clog2(MAP_W);
  localparam int YW        = $clog2(MAP_H);
  localparam int MAP_AW    = XW + YW;
  localparam int MAP_DEPTH = MAP_W * MAP_H;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_OUT  = 2'd1;
  localparam logic [1:0] ST_LIM  = 2'd2;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_WEST  = 2'd2;
  localparam logic [1:0] FACE_EAST  = 2'd3;

  localparam logic [2:0] REG_EYE_X = 3'd0;
  localparam logic [2:0] REG_EYE_Y = 3'd1;
  localparam logic [2:0] REG_ROWS  = 3'd2;
  localparam logic [2:0] REG_TEX_N = 3'd3;
  localparam logic [2:0] REG_TEX_S = 3'd4;
  localparam logic [2:0] REG_TEX_W = 3'd5;
  localparam logic [2:0] REG_TEX_E = 3'd6;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_STEP, S_LOOK, S_TEST, S_DIV, S_MUL, S_TEX, S_DONE
  } grdda_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic step;
    logic look;
    logic div_start;
    logic div_iter;
    logic mul;
    logic tex;
    logic emit;
    logic emit_err;
    logic [1:0] err_code;
  } grdda_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic is_cast;
    logic out_of_map;
    logic is_wall;
    logic limit;
    logic div_done;
  } grdda_sts_t;

endpackage

### rtl/grdda_ctrl.sv
// Controller state machine of the grid ray caster.
module grdda_ctrl import grdda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  grdda_sts_t sts,
  output logic       busy,
  output grdda_cmd_t cmd
);

  grdda_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (start && sts.is_cast) state_nxt = S_STEP;
      S_STEP:  state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_TEST;
      S_TEST: begin
        if (sts.out_of_map) state_nxt = S_IDLE;
        else if (sts.is_wall) state_nxt = S_DIV;
        else if (sts.limit) state_nxt = S_IDLE;
        else state_nxt = S_STEP;
      end
      S_DIV:   if (sts.div_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_TEX;
      S_TEX:   state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      S_CLEAR: cmd.clr_en = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      S_STEP: cmd.step = 1'b1;
      S_LOOK: cmd.look = 1'b1;
      S_TEST: begin
        if (sts.out_of_map) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = ST_OUT;
        end else if (sts.is_wall) begin
          cmd.div_start = 1'b1;
        end else if (sts.limit) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = ST_LIM;
        end
      end
      S_DIV:  cmd.div_iter = 1'b1;
      S_MUL:  cmd.mul = 1'b1;
      S_TEX:  cmd.tex = 1'b1;
      S_DONE: cmd.emit = 1'b1;
      default: ;
    endcase
  end

endmodule

### rtl/grdda_dp.sv
// Datapath of the grid ray caster: map memory, DDA registers, divider, texture math.
module grdda_dp import grdda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  grdda_cmd_t  cmd,
  output grdda_sts_t  sts,
  input  logic        in_action,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic        in_is_wall,
  input  logic        in_step_x_negative,
  input  logic        in_step_y_negative,
  input  logic [31:0] in_side_dist_x,
  input  logic [31:0] in_side_dist_y,
  input  logic [31:0] in_delta_dist_x,
  input  logic [31:0] in_delta_dist_y,
  input  logic signed [31:0] in_ray_dir_x,
  input  logic signed [31:0] in_ray_dir_y,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_facing,
  output logic [31:0] out_distance,
  output logic [15:0] out_column_height,
  output logic [11:0] out_top_row,
  output logic [11:0] out_bottom_row,
  output logic [9:0]  out_texture_column
);

  // configuration
  logic [21:0] eye_x_r, eye_y_r;
  logic [12:0] rows_r;
  logic [10:0] texw_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      rows_r  <= 13'd480;
      for (int i = 0; i < 4; i++) texw_r[i] <= 11'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EYE_X: eye_x_r <= cfg_data[21:0];
        REG_EYE_Y: eye_y_r <= cfg_data[21:0];
        REG_ROWS:  rows_r  <= cfg_data[12:0];
        REG_TEX_N: texw_r[0] <= cfg_data[10:0];
        REG_TEX_S: texw_r[1] <= cfg_data[10:0];
        REG_TEX_W: texw_r[2] <= cfg_data[10:0];
        REG_TEX_E: texw_r[3] <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // wall map with clearing sweep
  logic              map_mem [MAP_DEPTH];
  logic [MAP_AW:0]   clr_cnt_r;
  logic              map_rd_r;
  logic [XW-1:0]     x_r;
  logic [YW-1:0]     y_r;
  logic              oom_r;
  logic              wr_en;
  logic [MAP_AW-1:0] wr_addr;
  logic              wr_data;

  assign sts.clr_done = clr_cnt_r[MAP_AW];

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_en && !clr_cnt_r[MAP_AW]) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {in_cell_y[YW-1:0], in_cell_x[XW-1:0]};
    wr_data = in_is_wall;
    if (cmd.clr_en) begin
      wr_en   = !clr_cnt_r[MAP_AW];
      wr_addr = clr_cnt_r[MAP_AW-1:0];
      wr_data = 1'b0;
    end else if (cmd.load && !in_action) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    map_rd_r <= map_mem[{y_r, x_r}];
  end

  assign sts.is_cast = in_action;

  // DDA registers
  logic [31:0] dx_r, dy_r;
  logic signed [31:0] rdx_r, rdy_r;
  logic        sxn_r, syn_r, ew_r;
  logic [1:0]  face_r;
  logic [STEP_W-1:0] n_r;
  logic [XW:0] x_nxt_w;
  logic [YW:0] y_nxt_w;

  always_comb begin
    x_nxt_w = sxn_r ? {1'b0, x_r} - 1'b1 : {1'b0, x_r} + 1'b1;
    y_nxt_w = syn_r ? {1'b0, y_r} - 1'b1 : {1'b0, y_r} + 1'b1;
  end

  // side distances grow up to MAX_STEPS deltas; keep a wide copy
  logic [40:0] sdx_r, sdy_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sdx_r <= {9'd0, in_side_dist_x};
      sdy_r <= {9'd0, in_side_dist_y};
      dx_r <= in_delta_dist_x;
      dy_r <= in_delta_dist_y;
      rdx_r <= in_ray_dir_x;
      rdy_r <= in_ray_dir_y;
      sxn_r <= in_step_x_negative;
      syn_r <= in_step_y_negative;
      x_r <= in_cell_x[XW-1:0];
      y_r <= in_cell_y[YW-1:0];
      n_r <= '0;
      oom_r <= 1'b0;
    end else if (cmd.step) begin
      n_r <= n_r + 1'b1;
      if (sdx_r < sdy_r) begin
        sdx_r <= sdx_r + {9'd0, dx_r};
        x_r <= x_nxt_w[XW-1:0];
        oom_r <= sxn_r ? (x_r == '0) : (x_nxt_w >= (XW+1)'(MAP_W));
        ew_r <= 1'b1;
        face_r <= sxn_r ? FACE_EAST : FACE_WEST;
      end else begin
        sdy_r <= sdy_r + {9'd0, dy_r};
        y_r <= y_nxt_w[YW-1:0];
        oom_r <= syn_r ? (y_r == '0) : (y_nxt_w >= (YW+1)'(MAP_H));
        ew_r <= 1'b0;
        face_r <= syn_r ? FACE_SOUTH : FACE_NORTH;
      end
    end
  end

  assign sts.out_of_map = oom_r;
  assign sts.is_wall = map_rd_r;
  assign sts.limit = (n_r == STEP_W'(MAX_STEPS));

  // distance
  logic [40:0] full_w;
  logic [31:0] dist_w;
  assign full_w = ew_r ? sdx_r - {9'd0, dx_r} : sdy_r - {9'd0, dy_r};
  assign dist_w = (|full_w[40:32]) ? 32'hFFFF_FFFF : full_w[31:0];

  // restoring divider: (rows << 16) / dist, 29-bit dividend
  logic [31:0] dist_r;
  logic [28:0] quo_r;
  logic [32:0] rem_r;
  logic [4:0]  dcnt_r;
  logic [32:0] trial_w;
  logic [28:0] dividend_r;

  assign trial_w = {rem_r[31:0], dividend_r[28]};
  assign sts.div_done = (dcnt_r == 5'd28);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dist_r <= dist_w;
      dividend_r <= {rows_r, 16'd0};
      rem_r <= '0;
      quo_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_iter) begin
      dcnt_r <= dcnt_r + 1'b1;
      dividend_r <= {dividend_r[27:0], 1'b0};
      if (trial_w >= {1'b0, dist_r}) begin
        rem_r <= trial_w - {1'b0, dist_r};
        quo_r <= {quo_r[27:0], 1'b1};
      end else begin
        rem_r <= trial_w;
        quo_r <= {quo_r[27:0], 1'b0};
      end
    end
  end

  // final quotient includes this cycle's bit
  logic [28:0] q_fin_w;
  assign q_fin_w = {quo_r[27:0], (trial_w >= {1'b0, dist_r})};

  logic [15:0] h_r;
  logic [63:0] prod_r;
  logic [31:0] frac_r;
  logic [10:0] w_r;
  logic        mirror_r;
  logic [21:0] eye_w;
  logic signed [31:0] dir_w;

  assign eye_w = ew_r ? eye_y_r : eye_x_r;
  assign dir_w = ew_r ? rdy_r : rdx_r;

  always_ff @(posedge clk) begin
    if (cmd.div_iter && sts.div_done) begin
      if (dist_r == '0) h_r <= {3'd0, rows_r};
      else h_r <= (|q_fin_w[28:16]) ? 16'hFFFF : q_fin_w[15:0];
      // low 32 bits of dist * signed dir
      prod_r <= $signed({1'b0, dist_r}) * dir_w;
    end
    if (cmd.mul) begin
      frac_r <= {eye_w[15:0], 16'd0} + prod_r[31:0];
      w_r <= texw_r[face_r];
      mirror_r <= ew_r ? (!rdx_r[31] && rdx_r != '0) : rdy_r[31];
    end
  end

  logic [42:0] tp_r;
  always_ff @(posedge clk) begin
    if (cmd.tex) tp_r <= frac_r * w_r;
  end

  // result
  logic [11:0] half_w;
  logic [14:0] hh_w;
  logic [15:0] bot_w;
  logic [12:0] top_w;
  logic [10:0] tex_w, texm_w;
  logic [11:0] texs_w;

  always_comb begin
    half_w = rows_r[12:1];
    hh_w   = h_r[15:1];
    bot_w  = {1'b0, hh_w} + {4'd0, half_w};
    if (rows_r == '0) bot_w = '0;
    else if (bot_w >= {3'd0, rows_r}) bot_w = {3'd0, rows_r} - 1'b1;
    if (bot_w > 16'd4095) bot_w = 16'd4095;
    top_w = (hh_w > {3'd0, half_w}) ? '0 : 13'({3'd0, half_w} - hh_w);
    tex_w  = tp_r[42:32];
    texm_w = mirror_r ? w_r - tex_w - 1'b1 : tex_w;
    texs_w = {1'b0, texm_w};
    if (w_r == '0) texs_w = '0;
    else if (texs_w > 12'd1023) texs_w = 12'd1023;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit || cmd.emit_err;
    if (cmd.emit_err) begin
      out_status <= cmd.err_code;
      out_facing <= '0;
      out_distance <= '0;
      out_column_height <= '0;
      out_top_row <= '0;
      out_bottom_row <= '0;
      out_texture_column <= '0;
    end else if (cmd.emit) begin
      out_status <= ST_HIT;
      out_facing <= face_r;
      out_distance <= dist_r;
      out_column_height <= h_r;
      out_top_row <= top_w[11:0];
      out_bottom_row <= bot_w[11:0];
      out_texture_column <= texs_w[9:0];
    end
  end

endmodule

### rtl/grid_raycast_dda.sv
// Top level of the grid ray caster: controller plus datapath.
//
// A write item (action 0) updates one wall-map cell and gives no result. A
// cast item (action 1) steps the DDA one cell at a time through its step,
// map read and test states, for up to 128 steps. After a hit the 29-iteration
// restoring divider finds the column height, and the mul and tex states finish
// the texture math. After reset the 4096-entry wall map is cleared one cell a
// cycle, with busy high. Results appear for one cycle on out_valid and cannot
// be stalled; configuration writes are always accepted (cfg_ready high).
module grid_raycast_dda import grdda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic        in_is_wall,
  input  logic        in_step_x_negative,
  input  logic        in_step_y_negative,
  input  logic [31:0] in_side_dist_x,
  input  logic [31:0] in_side_dist_y,
  input  logic [31:0] in_delta_dist_x,
  input  logic [31:0] in_delta_dist_y,
  input  logic signed [31:0] in_ray_dir_x,
  input  logic signed [31:0] in_ray_dir_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_facing,
  output logic [31:0] out_distance,
  output logic [15:0] out_column_height,
  output logic [11:0] out_top_row,
  output logic [11:0] out_bottom_row,
  output logic [9:0]  out_texture_column
);

  grdda_cmd_t cmd;
  grdda_sts_t sts;

  assign cfg_ready = 1'b1;

  grdda_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
  );

  grdda_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .in_is_wall(in_is_wall), .in_step_x_negative(in_step_x_negative),
    .in_step_y_negative(in_step_y_negative),
    .in_side_dist_x(in_side_dist_x), .in_side_dist_y(in_side_dist_y),
    .in_delta_dist_x(in_delta_dist_x), .in_delta_dist_y(in_delta_dist_y),
    .in_ray_dir_x(in_ray_dir_x), .in_ray_dir_y(in_ray_dir_y),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_status(out_status), .out_facing(out_facing),
    .out_distance(out_distance), .out_column_height(out_column_height),
    .out_top_row(out_top_row), .out_bottom_row(out_bottom_row),
    .out_texture_column(out_texture_column)
  );

endmodule

### rtl/grdda_checker.sv
// Port-level checker for the grid ray caster, bound to the top level.
module grdda_checker import grdda_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_action,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [1:0] out_facing,
  input logic [31:0] out_distance
);

  a_no_status3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_HIT) |-> (out_facing == '0 && out_distance == '0))
    else $error("error result not zeroed");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_action) |=> !busy) else $error("write held block");

endmodule

bind grid_raycast_dda grdda_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_action(in_action),
  .out_valid(out_valid), .out_status(out_status), .out_facing(out_facing),
  .out_distance(out_distance)
);

### tb/tb.sv
// Self-checking testbench for the grid ray caster: map writes, ray casts, register settings.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grdda_pkg::*;

  // register index past the last one; the block must ignore it
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 600;
  localparam int PHASE_ITEMS = 286;

  typedef struct {
    bit        action;
    bit [5:0]  cx, cy;
    bit        wall, sxn, syn;
    bit [31:0] sdx, sdy, ddx, ddy, rdx, rdy;
  } ray_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  facing;
    logic [31:0] distance;
    logic [15:0] height;
    logic [11:0] top;
    logic [11:0] bottom;
    logic [9:0]  texcol;
  } hit_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_action, in_is_wall, in_step_x_negative, in_step_y_negative;
  logic [5:0] in_cell_x, in_cell_y;
  logic [31:0] in_side_dist_x, in_side_dist_y, in_delta_dist_x, in_delta_dist_y;
  logic signed [31:0] in_ray_dir_x, in_ray_dir_y;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic out_valid;
  logic [1:0] out_status, out_facing;
  logic [31:0] out_distance;
  logic [15:0] out_column_height;
  logic [11:0] out_top_row, out_bottom_row;
  logic [9:0] out_texture_column;

  grid_raycast_dda dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's state
  bit        walls [MAP_W*MAP_H];
  bit [21:0] eye_x_q, eye_y_q;
  bit [12:0] rows_q;
  bit [10:0] tex_w_q [4];

  ray_item_t   pending_items [$];
  hit_report_t expected_hits [$];
  int          errors = 0;
  bit          idle_en = 1'b1;
  int          gap_left = 0;
  ray_item_t   cur;

  // Walk the ray through the shadow map and build the report it should give.
  function automatic hit_report_t trace_ray(ray_item_t it);
    hit_report_t r;
    int x, y, sx, sy;
    longint unsigned side_x, side_y, dx, dy, full, dist_v, h, eye, dir, pos, frac, w, tex;
    longint half, hh, bot, top;
    logic [1:0] face;
    bit hit, ew, dx_pos;
    r = '0;
    x = it.cx; y = it.cy;
    sx = it.sxn ? -1 : 1;
    sy = it.syn ? -1 : 1;
    side_x = it.sdx; side_y = it.sdy; dx = it.ddx; dy = it.ddy;
    face = FACE_NORTH;
    hit = 1'b0;
    for (int n = 0; n < MAX_STEPS; n++) begin
      if (side_x < side_y) begin
        side_x += dx; x += sx;
        face = (sx > 0) ? FACE_WEST : FACE_EAST;
      end else begin
        side_y += dy; y += sy;
        face = (sy > 0) ? FACE_NORTH : FACE_SOUTH;
      end
      if (x < 0 || x >= MAP_W || y < 0 || y >= MAP_H) begin
        r.status = ST_OUT;
        return r;
      end
      if (walls[y*MAP_W + x]) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      r.status = ST_LIM;
      return r;
    end
    ew   = (face == FACE_WEST || face == FACE_EAST);
    full = ew ? side_x - dx : side_y - dy;
    dist_v = (full > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : full;
    if (dist_v == 0) h = rows_q;
    else begin
      h = (longint'(rows_q) << 16) / dist_v;
      if (h > 64'hFFFF) h = 64'hFFFF;
    end
    half = rows_q / 2;
    hh   = h / 2;
    bot  = hh + half;
    if (bot >= longint'(rows_q)) bot = longint'(rows_q) - 1;
    if (bot < 0) bot = 0;
    if (bot > 4095) bot = 4095;
    top = half - hh;
    if (top < 0) top = 0;
    // hit point in Q32.32 mod 2^64, only the fraction matters
    eye  = ew ? eye_y_q : eye_x_q;
    dir  = ew ? {{32{it.rdy[31]}}, it.rdy} : {{32{it.rdx[31]}}, it.rdx};
    pos  = (eye << 16) + dist_v * dir;
    frac = pos & 64'hFFFF_FFFF;
    w    = tex_w_q[face];
    tex  = 0;
    if (w != 0) begin
      tex = (frac * w) >> 32;
      dx_pos = !it.rdx[31] && it.rdx != 0;
      if ((ew && dx_pos) || (!ew && it.rdy[31])) tex = w - tex - 1;
      if (tex > 1023) tex = 1023;
    end
    r.status   = ST_HIT;
    r.facing   = face;
    r.distance = dist_v[31:0];
    r.height   = h[15:0];
    r.top      = top[11:0];
    r.bottom   = bot[11:0];
    r.texcol   = tex[9:0];
    return r;
  endfunction

  // Driver: one item per accept, random idle bursts while idle_en is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur.action) expected_hits.push_back(trace_ray(cur));
        else walls[cur.cy*MAP_W + cur.cx] = cur.wall;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() != 0 && idle_en && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(1, 10) - 1;
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          in_action          <= cur.action;
          in_cell_x          <= cur.cx;
          in_cell_y          <= cur.cy;
          in_is_wall         <= cur.wall;
          in_step_x_negative <= cur.sxn;
          in_step_y_negative <= cur.syn;
          in_side_dist_x     <= cur.sdx;
          in_side_dist_y     <= cur.sdy;
          in_delta_dist_x    <= cur.ddx;
          in_delta_dist_y    <= cur.ddy;
          in_ray_dir_x       <= cur.rdx;
          in_ray_dir_y       <= cur.rdy;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Monitor: results last one cycle, compare against the oldest prediction.
  always @(posedge clk) begin
    hit_report_t e;
    if (rst_n && out_valid) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h", $time, out_status);
        errors++;
      end else begin
        e = expected_hits.pop_front();
        check_field("status", e.status, out_status);
        check_field("facing", e.facing, out_facing);
        check_field("distance", e.distance, out_distance);
        check_field("column_height", e.height, out_column_height);
        check_field("top_row", e.top, out_top_row);
        check_field("bottom_row", e.bottom, out_bottom_row);
        check_field("texture_column", e.texcol, out_texture_column);
      end
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[grid_raycast_dda] ERROR");
      $finish;
    end
  end

  // Register write; call right after posedge clk, block must be idle.
  // cfg_valid stays high for back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [2:0] idx, input bit [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EYE_X: eye_x_q = val[21:0];
      REG_EYE_Y: eye_y_q = val[21:0];
      REG_ROWS:  rows_q  = val[12:0];
      REG_TEX_N: tex_w_q[FACE_NORTH] = val[10:0];
      REG_TEX_S: tex_w_q[FACE_SOUTH] = val[10:0];
      REG_TEX_W: tex_w_q[FACE_WEST]  = val[10:0];
      REG_TEX_E: tex_w_q[FACE_EAST]  = val[10:0];
      default: ;
    endcase
  endtask

  // Wait for every item to go in and every result to come out, then let any
  // trailing work finish.
  task automatic drain();
    do @(posedge clk); while (pending_items.size() != 0 || start || expected_hits.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_write(bit [5:0] x, bit [5:0] y, bit w);
    ray_item_t it;
    it = '{default: '0};
    it.cx = x; it.cy = y; it.wall = w;
    it.sdx = $urandom; it.rdy = $urandom;   // don't-care fields still toggle
    pending_items.push_back(it);
  endfunction

  function automatic void add_cast(bit [5:0] x, bit [5:0] y, bit sxn, bit syn,
                                   bit [31:0] sdx, bit [31:0] sdy, bit [31:0] ddx,
                                   bit [31:0] ddy, bit [31:0] rdx, bit [31:0] rdy);
    ray_item_t it;
    it = '{action: 1'b1, cx: x, cy: y, wall: $urandom_range(0, 1), sxn: sxn, syn: syn,
           sdx: sdx, sdy: sdy, ddx: ddx, ddy: ddy, rdx: rdx, rdy: rdy};
    pending_items.push_back(it);
  endfunction

  // Map writes and mostly plausible rays (signs match steps, side <= delta), some raw noise.
  function automatic void add_random_item();
    bit sxn, syn;
    bit [31:0] ddx, ddy, rdx, rdy;
    if ($urandom_range(0, 99) < 35) begin
      add_write($urandom, $urandom, $urandom_range(0, 2) == 0);
    end else if ($urandom_range(0, 99) < 85) begin
      sxn = $urandom; syn = $urandom;
      ddx = $urandom_range(32'h4000, 32'h80000);
      ddy = $urandom_range(32'h4000, 32'h80000);
      rdx = $urandom_range(0, 32'h20000);
      rdy = $urandom_range(0, 32'h20000);
      if (sxn) rdx = -rdx;
      if (syn) rdy = -rdy;
      add_cast($urandom, $urandom, sxn, syn, $urandom_range(0, ddx), $urandom_range(0, ddy),
               ddx, ddy, rdx, rdy);
    end else begin
      add_cast($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    start <= 1'b0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_action <= 1'b0; in_cell_x <= '0; in_cell_y <= '0; in_is_wall <= 1'b0;
    in_step_x_negative <= 1'b0; in_step_y_negative <= 1'b0;
    in_side_dist_x <= '0; in_side_dist_y <= '0; in_delta_dist_x <= '0; in_delta_dist_y <= '0;
    in_ray_dir_x <= '0; in_ray_dir_y <= '0;
    eye_x_q = 0; eye_y_q = 0; rows_q = 480;
    foreach (tex_w_q[i]) tex_w_q[i] = 64;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty map, so every direction runs off the edge
    add_cast(5, 5, 0, 0, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 32'hFFFF_FFFF, 32'h10000, 0);
    add_cast(5, 5, 1, 0, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    add_cast(5, 5, 0, 0, 32'hFFFF_FFFF, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 0, 32'h7FFF_FFFF);
    add_cast(5, 5, 0, 1, 32'hFFFF_FFFF, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 0, 32'hFFFF_8000);
    // one wall per face around (5,5)
    add_write(8, 5, 1); add_write(2, 5, 1); add_write(5, 8, 1); add_write(5, 2, 1);
    add_cast(5, 5, 0, 0, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 32'hFFFF_FFFF, 32'h18000, 32'h3000);
    add_cast(5, 5, 1, 1, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 32'hFFFF_FFFF, 32'hFFFF_8000,
             32'hFFFF_F000);
    add_cast(5, 5, 0, 0, 32'hFFFF_FFFF, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 32'h2000, 32'h18000);
    add_cast(5, 5, 1, 1, 32'hFFFF_FFFF, 32'h8000, 32'hFFFF_FFFF, 32'h10000, 32'hFFFF_E000,
             32'h8000_0000);
    // zero distance: wall right next door, all distances zero
    add_write(5, 6, 1);
    add_cast(5, 5, 0, 0, 0, 0, 0, 0, 32'h1234, 32'h10000);
    // clear a wall, then cast through where it was
    add_write(5, 6, 0);
    add_cast(5, 5, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1);
    // corner start cells
    add_cast(0, 0, 1, 1, 0, 0, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'hFFFF_0000);
    add_cast(63, 63, 0, 0, 1, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    drain();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_EYE_X, 0); write_reg(REG_EYE_Y, 4194303); write_reg(REG_ROWS, 1);
          write_reg(REG_TEX_N, 1); write_reg(REG_TEX_S, 1024);
          write_reg(REG_TEX_W, 1); write_reg(REG_TEX_E, 1024);
          write_reg(REG_SPARE, $urandom);
        end
        2: begin
          write_reg(REG_EYE_X, 4194303); write_reg(REG_EYE_Y, 0); write_reg(REG_ROWS, 4096);
          write_reg(REG_TEX_N, 1024); write_reg(REG_TEX_S, 1);
          write_reg(REG_TEX_W, 7); write_reg(REG_TEX_E, 33);
        end
        3: begin
          // zero rows and zero widths, plus a width past 1023
          write_reg(REG_EYE_X, $urandom_range(0, 4194303));
          write_reg(REG_EYE_Y, $urandom_range(0, 4194303));
          write_reg(REG_ROWS, 0);
          write_reg(REG_TEX_N, 0); write_reg(REG_TEX_S, 0);
          write_reg(REG_TEX_W, 2047); write_reg(REG_TEX_E, 64);
        end
        4: begin
          write_reg(REG_EYE_X, $urandom); write_reg(REG_EYE_Y, $urandom);
          write_reg(REG_ROWS, 8191);
          write_reg(REG_TEX_N, $urandom_range(1, 1024)); write_reg(REG_TEX_S, $urandom_range(1, 1024));
          write_reg(REG_TEX_W, $urandom_range(1, 1024)); write_reg(REG_TEX_E, $urandom_range(1, 1024));
        end
        default: begin
          idle_en = 1'b0;   // last stretch runs back to back
          write_reg(REG_EYE_X, $urandom_range(0, 4194303));
          write_reg(REG_EYE_Y, $urandom_range(0, 4194303));
          write_reg(REG_ROWS, $urandom_range(1, 4096));
          write_reg(REG_TEX_N, $urandom_range(1, 1024)); write_reg(REG_TEX_S, $urandom_range(1, 1024));
          write_reg(REG_TEX_W, $urandom_range(1, 1024)); write_reg(REG_TEX_E, $urandom_range(1, 1024));
        end
      endcase
      cfg_valid <= 1'b0;
      repeat (PHASE_ITEMS) add_random_item();
      drain();
    end

    if (errors == 0) begin
      $display("[grid_raycast_dda] OK");
    end else begin
      $display("[grid_raycast_dda] ERROR");
    end
    $finish;
  end

endmodule
